@@ rtl/assert_macros.svh @@
// assertion helpers, clocked on clk and quiet while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define PQSI_AST_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define PQSI_AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/pqsi_pkg.sv @@
package pqsi_pkg;

  typedef enum logic [2:0] {
    ACT_ENQ     = 3'd0,
    ACT_DEQ     = 3'd1,
    ACT_BOOST   = 3'd2,
    ACT_RESTORE = 3'd3,
    ACT_FLUSH   = 3'd4
  } act_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  localparam logic CFG_STARVE_LIMIT = 1'b0;
  localparam logic CFG_NORMAL_LEVEL = 1'b1;

  typedef struct packed {
    logic [1:0] engine;
    logic [3:0] pri;
    logic [3:0] orig;
    logic [5:0] channel;
  } meta_t;

endpackage

@@ rtl/priority_queue_starvation_inherit_top.sv @@
// channel  direction  handshake             payload
// in       input      in_valid/in_ready     action, payload, engine, priority_req, channel
// out      output     out_valid/out_ready   status, forced, dequeued entry fields
// cfg      input      cfg_valid/cfg_ready   register index, write data
//
// enqueue, dequeue, boost and restore scan every slot in turn (S_SCAN), then pass
// S_TAIL for the last memory read, S_FIN, S_PAY on a dequeue that finds an entry,
// and S_DONE; flush and unknown actions go from S_IDLE straight to S_DONE.
// synchronous reset clears slot and channel valid bits, age and starvation counters.
// a result waiting on out_ready holds the next finished item in its last step only.
module priority_queue_starvation_inherit_top #(
  parameter int QUEUE_DEPTH   = 32,
  parameter int CHANNEL_COUNT = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              in_action,
  input  logic [63:0]             in_payload,
  input  logic [1:0]              in_engine,
  input  logic [3:0]              in_priority_req,
  input  logic [5:0]              in_channel,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_status,
  output logic                    out_forced,
  output logic [63:0]             out_payload,
  output logic [1:0]              out_engine,
  output logic [3:0]              out_priority,
  output logic [3:0]              out_original,
  output logic [5:0]              out_channel,
  output logic [63:0]             out_age,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_index,
  input  logic [15:0]             cfg_data
);
  import pqsi_pkg::*;

  localparam int QW         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CH_ENTRIES = (CHANNEL_COUNT < 64) ? CHANNEL_COUNT : 64;
  localparam int CHW        = (CH_ENTRIES > 1) ? $clog2(CH_ENTRIES) : 1;
  localparam logic [QW-1:0] LAST_IDX = QW'(QUEUE_DEPTH - 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_TAIL = 6'b000100,
    S_FIN  = 6'b001000,
    S_PAY  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [15:0] limit_r;
  logic [3:0]  normal_r;

  logic [QUEUE_DEPTH-1:0] valid_r;
  logic [CH_ENTRIES-1:0]  chv_r;
  logic [63:0]            age_cnt_r;
  logic [15:0]            starve_r;

  logic [63:0] pay_mem  [QUEUE_DEPTH];
  logic [63:0] age_mem  [QUEUE_DEPTH];
  meta_t       meta_mem [QUEUE_DEPTH];
  logic [3:0]  inh_mem  [CH_ENTRIES];

  logic [63:0] pay_rd_r, age_rd_r;
  meta_t       meta_rd_r;
  logic [3:0]  inh_rd_r;

  act_t        act_r;
  logic [63:0] pay_r;
  logic [1:0]  eng_r;
  logic [3:0]  preq_r;
  logic [5:0]  ch_r;
  logic        ch_ok_r;
  logic        inh_ok_r;

  logic [QW-1:0] scan_idx_r, rd_idx_r;
  logic          rd_vld_r;

  logic          free_found_r;
  logic [QW-1:0] free_idx_r;
  logic          f_found_r, n_found_r;
  logic [QW-1:0] f_idx_r, n_idx_r;
  logic [63:0]   f_age_r, n_age_r;
  meta_t         f_meta_r, n_meta_r;

  logic          use_f_r;
  logic [QW-1:0] pick_idx_r;
  meta_t         pick_meta_r;
  logic [63:0]   pick_age_r;
  logic          res_deq_r;
  status_t       res_status_r;

  logic        out_valid_r, out_forced_r;
  logic [1:0]  out_status_r;
  logic [63:0] out_payload_r, out_age_r;
  meta_t       out_meta_r;

  logic          accept;
  logic          sv;
  logic          use_f;
  logic          meta_we;
  logic [QW-1:0] meta_wa;
  meta_t         meta_wd;
  meta_t         enq_meta;
  logic          out_load;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign sv        = valid_r[rd_idx_r];
  assign use_f     = (starve_r >= limit_r) && f_found_r;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    enq_meta.engine  = eng_r;
    enq_meta.orig    = preq_r;
    enq_meta.channel = ch_r;
    enq_meta.pri     = (inh_ok_r && inh_rd_r > preq_r) ? inh_rd_r : preq_r;
    meta_we = 1'b0;
    meta_wa = rd_idx_r;
    meta_wd = meta_rd_r;
    if (state_r == S_FIN && act_r == ACT_ENQ && free_found_r) begin
      meta_we = 1'b1;
      meta_wa = free_idx_r;
      meta_wd = enq_meta;
    end else if (rd_vld_r && sv && meta_rd_r.channel == ch_r) begin
      if (act_r == ACT_BOOST && meta_rd_r.pri < preq_r) begin
        meta_we    = 1'b1;
        meta_wd.pri = preq_r;
      end else if (act_r == ACT_RESTORE) begin
        meta_we    = 1'b1;
        meta_wd.pri = meta_rd_r.orig;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_action == ACT_ENQ || in_action == ACT_DEQ || in_action == ACT_BOOST ||
              in_action == ACT_RESTORE) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: if (scan_idx_r == LAST_IDX) state_nxt = S_TAIL;
      S_TAIL: state_nxt = S_FIN;
      S_FIN: begin
        if (act_r == ACT_DEQ && (f_found_r || n_found_r)) state_nxt = S_PAY;
        else state_nxt = S_DONE;
      end
      S_PAY:  state_nxt = S_DONE;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // slot memories; the channel memory follows
  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    if (state_r == S_FIN && act_r == ACT_ENQ && free_found_r) begin
      pay_mem[free_idx_r] <= pay_r;
      age_mem[free_idx_r] <= age_cnt_r;
    end
    meta_rd_r <= meta_mem[scan_idx_r];
    age_rd_r  <= age_mem[scan_idx_r];
    if (state_r == S_FIN) pay_rd_r <= pay_mem[use_f ? f_idx_r : n_idx_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && act_r == ACT_BOOST && ch_ok_r) inh_mem[ch_r[CHW-1:0]] <= preq_r;
    if (accept) inh_rd_r <= inh_mem[in_channel[CHW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= 16'd16;
      normal_r    <= 4'd4;
      valid_r     <= '0;
      chv_r       <= '0;
      age_cnt_r   <= '0;
      starve_r    <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_STARVE_LIMIT) limit_r <= cfg_data;
        else normal_r <= cfg_data[3:0];
      end
      rd_vld_r <= (state_r == S_SCAN);
      if (accept && in_action == ACT_FLUSH) begin
        valid_r  <= '0;
        chv_r    <= '0;
        starve_r <= '0;
      end
      if (state_r == S_FIN) begin
        if (act_r == ACT_ENQ && free_found_r) begin
          valid_r[free_idx_r] <= 1'b1;
          age_cnt_r           <= age_cnt_r + 64'd1;
        end
        if (act_r == ACT_BOOST && ch_ok_r) chv_r[ch_r[CHW-1:0]] <= 1'b1;
        if (act_r == ACT_RESTORE && ch_ok_r) chv_r[ch_r[CHW-1:0]] <= 1'b0;
      end
      if (state_r == S_PAY) begin
        valid_r[pick_idx_r] <= 1'b0;
        if (use_f_r || pick_meta_r.pri <= normal_r) starve_r <= '0;
        else if (starve_r != 16'hFFFF) starve_r <= starve_r + 16'd1;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r        <= act_t'(in_action);
      pay_r        <= in_payload;
      eng_r        <= in_engine;
      preq_r       <= in_priority_req;
      ch_r         <= in_channel;
      ch_ok_r      <= 32'(in_channel) < CHANNEL_COUNT;
      inh_ok_r     <= (32'(in_channel) < CHANNEL_COUNT) && chv_r[in_channel[CHW-1:0]];
      scan_idx_r   <= '0;
      free_found_r <= 1'b0;
      f_found_r    <= 1'b0;
      n_found_r    <= 1'b0;
      res_deq_r    <= 1'b0;
      res_status_r <= ST_DONE;
    end
    if (state_r == S_SCAN) begin
      scan_idx_r <= scan_idx_r + QW'(1);
      rd_idx_r   <= scan_idx_r;
    end
    if (rd_vld_r) begin
      if (!sv && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= rd_idx_r;
      end
      if (sv && meta_rd_r.pri <= normal_r && (!f_found_r || age_rd_r < f_age_r)) begin
        f_found_r <= 1'b1;
        f_idx_r   <= rd_idx_r;
        f_age_r   <= age_rd_r;
        f_meta_r  <= meta_rd_r;
      end
      if (sv && (!n_found_r || meta_rd_r.pri > n_meta_r.pri ||
                 (meta_rd_r.pri == n_meta_r.pri && age_rd_r < n_age_r))) begin
        n_found_r <= 1'b1;
        n_idx_r   <= rd_idx_r;
        n_age_r   <= age_rd_r;
        n_meta_r  <= meta_rd_r;
      end
    end
    if (state_r == S_FIN) begin
      use_f_r     <= use_f;
      pick_idx_r  <= use_f ? f_idx_r : n_idx_r;
      pick_age_r  <= use_f ? f_age_r : n_age_r;
      pick_meta_r <= use_f ? f_meta_r : n_meta_r;
      res_deq_r   <= (act_r == ACT_DEQ) && (f_found_r || n_found_r);
      if (act_r == ACT_ENQ && !free_found_r) res_status_r <= ST_FULL;
      if (act_r == ACT_DEQ && !(f_found_r || n_found_r)) res_status_r <= ST_EMPTY;
    end
    if (out_load) begin
      out_status_r  <= res_status_r;
      out_forced_r  <= res_deq_r && use_f_r;
      out_payload_r <= res_deq_r ? pay_rd_r : '0;
      out_age_r     <= res_deq_r ? pick_age_r : '0;
      out_meta_r    <= res_deq_r ? pick_meta_r : '0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_forced   = out_forced_r;
  assign out_payload  = out_payload_r;
  assign out_engine   = out_meta_r.engine;
  assign out_priority = out_meta_r.pri;
  assign out_original = out_meta_r.orig;
  assign out_channel  = out_meta_r.channel;
  assign out_age      = out_age_r;

endmodule

@@ rtl/pqsi_checker.sv @@
`include "assert_macros.svh"

module pqsi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic        out_forced,
  input logic [63:0] out_payload,
  input logic [3:0]  out_priority
);
  import pqsi_pkg::*;

  `PQSI_AST_IMPLY(a_status_code, out_valid, out_status != 2'd3)
  `PQSI_AST_IMPLY(a_fail_clean, out_valid && out_status != ST_DONE, !out_forced && out_payload == '0)
  `PQSI_AST_IMPLY(a_forced_done, out_valid && out_forced, out_status == ST_DONE)
  `PQSI_AST_NEXT(a_busy_after_transfer, in_valid && in_ready, !in_ready)
  `PQSI_AST_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_priority))

endmodule

bind priority_queue_starvation_inherit_top pqsi_checker u_pqsi_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_status   (out_status),
  .out_forced   (out_forced),
  .out_payload  (out_payload),
  .out_priority (out_priority)
);

@@ sim/priority_queue_starvation_inherit_top_tb.sv @@
module priority_queue_starvation_inherit_top_tb;
  import pqsi_pkg::*;

  localparam int QDEPTH = 32;
  localparam int NCHAN = 64;
  localparam logic [2:0] ACT_UNKNOWN = 3'd5;

  typedef struct packed {
    logic [1:0]  status;
    logic        forced;
    logic [63:0] payload;
    logic [1:0]  engine;
    logic [3:0]  pri;
    logic [3:0]  orig;
    logic [5:0]  channel;
    logic [63:0] age;
  } reply_t;

  class queue_scoreboard;
    logic [63:0] q_payload[QDEPTH];
    logic [63:0] q_age[QDEPTH];
    bit          q_valid[QDEPTH];
    meta_t       q_meta[QDEPTH];
    bit          inh_valid[NCHAN];
    logic [3:0]  inh_level[NCHAN];
    logic [63:0] age_ctr;
    logic [15:0] starve;
    logic [15:0] starve_limit;
    logic [3:0]  normal_lvl;
    reply_t      pending[$];
    int          mismatches;

    function new();
      for (int i = 0; i < QDEPTH; i++) q_valid[i] = 0;
      for (int i = 0; i < NCHAN; i++) inh_valid[i] = 0;
      age_ctr = 0;
      starve = 0;
      starve_limit = 16;
      normal_lvl = 4;
      mismatches = 0;
    endfunction

    function void set_reg(logic idx, logic [15:0] val);
      if (idx == CFG_STARVE_LIMIT) starve_limit = val;
      else normal_lvl = val[3:0];
    endfunction

    function void note_input(logic [2:0] act, logic [63:0] pl, logic [1:0] eng,
                             logic [3:0] preq, logic [5:0] ch);
      reply_t r;
      int slot;
      int pick;
      bit frc;
      logic [3:0] p;
      r = '0;
      if (act == ACT_ENQ) begin
        slot = -1;
        for (int i = 0; i < QDEPTH; i++)
          if (!q_valid[i] && slot < 0) slot = i;
        if (slot < 0) begin
          r.status = ST_FULL;
        end else begin
          p = preq;
          if (inh_valid[ch] && inh_level[ch] > p) p = inh_level[ch];
          q_valid[slot] = 1;
          q_payload[slot] = pl;
          q_age[slot] = age_ctr;
          q_meta[slot] = '{engine: eng, pri: p, orig: preq, channel: ch};
          age_ctr++;
        end
      end else if (act == ACT_DEQ) begin
        pick = -1;
        frc = 0;
        if (starve >= starve_limit) begin
          for (int i = 0; i < QDEPTH; i++)
            if (q_valid[i] && q_meta[i].pri <= normal_lvl)
              if (pick < 0 || q_age[i] < q_age[pick]) pick = i;
          if (pick >= 0) frc = 1;
        end
        if (pick < 0)
          for (int i = 0; i < QDEPTH; i++)
            if (q_valid[i])
              if (pick < 0 || q_meta[i].pri > q_meta[pick].pri ||
                  (q_meta[i].pri == q_meta[pick].pri && q_age[i] < q_age[pick]))
                pick = i;
        if (pick < 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.forced = frc;
          r.payload = q_payload[pick];
          r.engine = q_meta[pick].engine;
          r.pri = q_meta[pick].pri;
          r.orig = q_meta[pick].orig;
          r.channel = q_meta[pick].channel;
          r.age = q_age[pick];
          q_valid[pick] = 0;
          if (frc || q_meta[pick].pri <= normal_lvl) starve = 0;
          else if (starve != 16'hffff) starve++;
        end
      end else if (act == ACT_BOOST) begin
        inh_valid[ch] = 1;
        inh_level[ch] = preq;
        for (int i = 0; i < QDEPTH; i++)
          if (q_valid[i] && q_meta[i].channel == ch && q_meta[i].pri < preq)
            q_meta[i].pri = preq;
      end else if (act == ACT_RESTORE) begin
        inh_valid[ch] = 0;
        for (int i = 0; i < QDEPTH; i++)
          if (q_valid[i] && q_meta[i].channel == ch) q_meta[i].pri = q_meta[i].orig;
      end else if (act == ACT_FLUSH) begin
        for (int i = 0; i < QDEPTH; i++) q_valid[i] = 0;
        for (int i = 0; i < NCHAN; i++) inh_valid[i] = 0;
        starve = 0;
      end
      pending = {pending, r};
    endfunction

    function void check_reply(reply_t got);
      reply_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: %p", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_r, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [2:0] in_action = 0;
  logic [63:0] in_payload = 0;
  logic [1:0] in_engine = 0;
  logic [3:0] in_priority_req = 0;
  logic [5:0] in_channel = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [1:0] out_status;
  logic out_forced;
  logic [63:0] out_payload;
  logic [1:0] out_engine;
  logic [3:0] out_priority;
  logic [3:0] out_original;
  logic [5:0] out_channel;
  logic [63:0] out_age;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic cfg_index = 0;
  logic [15:0] cfg_data = 0;

  queue_scoreboard sb = new();
  int burst_left = 0;
  int stall_mode = 0;

  always #5 clk = ~clk;

  priority_queue_starvation_inherit_top u_dut (.*);

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_reply('{out_status, out_forced, out_payload, out_engine, out_priority,
                       out_original, out_channel, out_age});
  end

  always @(negedge clk) begin
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ~out_ready;
    endcase
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
  end

  task automatic send_item(logic [2:0] act, logic [63:0] pl, logic [1:0] eng,
                           logic [3:0] preq, logic [5:0] ch);
    @(negedge clk);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_action <= act;
    in_payload <= pl;
    in_engine <= eng;
    in_priority_req <= preq;
    in_channel <= ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(act, pl, eng, preq, ch);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic random_item(int deq_bias);
    int r;
    logic [2:0] act;
    r = $urandom_range(0, 99);
    if (r < 45) act = ACT_ENQ;
    else if (r < 45 + deq_bias) act = ACT_DEQ;
    else if (r < 88) act = ACT_BOOST;
    else if (r < 96) act = ACT_RESTORE;
    else if (r < 98) act = ACT_FLUSH;
    else act = 3'($urandom_range(5, 7));
    send_item(act, rand64(), 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
              ($urandom_range(0, 1)) ? 6'($urandom_range(0, 3)) : 6'($urandom_range(0, 63)));
  endtask

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed
    send_item(ACT_DEQ, 64'd0, 2'd0, 4'd0, 6'd0);
    send_item(ACT_ENQ, 64'hffff_ffff_ffff_ffff, 2'd3, 4'd15, 6'd63);
    send_item(ACT_ENQ, 64'd0, 2'd0, 4'd0, 6'd0);
    send_item(ACT_ENQ, 64'h1234, 2'd1, 4'd7, 6'd5);
    send_item(ACT_ENQ, 64'h5678, 2'd2, 4'd7, 6'd5);
    send_item(ACT_BOOST, 64'd0, 2'd0, 4'd12, 6'd5);
    send_item(ACT_ENQ, 64'h9abc, 2'd1, 4'd2, 6'd5);
    send_item(ACT_RESTORE, 64'd0, 2'd0, 4'd0, 6'd5);
    send_item(ACT_UNKNOWN, 64'd0, 2'd0, 4'd0, 6'd0);
    for (int i = 0; i < 6; i++) send_item(ACT_DEQ, 64'd0, 2'd0, 4'd0, 6'd0);
    for (int i = 0; i < 33; i++) send_item(ACT_ENQ, rand64(), 2'(i % 4), 4'(i % 16), 6'(i % 8));
    send_item(ACT_FLUSH, 64'd0, 2'd0, 4'd0, 6'd0);
    send_item(ACT_DEQ, 64'd0, 2'd0, 4'd0, 6'd0);
    write_reg(CFG_STARVE_LIMIT, 16'd0);
    write_reg(CFG_NORMAL_LEVEL, 16'd15);
    for (int i = 0; i < 120; i++) random_item(30);
    write_reg(CFG_STARVE_LIMIT, 16'd2);
    write_reg(CFG_NORMAL_LEVEL, 16'd0);
    for (int i = 0; i < 150; i++) random_item(30);
    drain();
    write_reg(CFG_STARVE_LIMIT, 16'hffff);
    write_reg(CFG_NORMAL_LEVEL, 16'd6);
    for (int i = 0; i < 150; i++) random_item(25);
    write_reg(CFG_STARVE_LIMIT, 16'd3);
    write_reg(CFG_NORMAL_LEVEL, 16'd4);
    for (int i = 0; i < 180; i++) random_item(i % 40 < 20 ? 5 : 38);
    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

@@ priority_queue_starvation_inherit_top.f @@
+incdir+rtl
rtl/pqsi_pkg.sv
rtl/priority_queue_starvation_inherit_top.sv
rtl/pqsi_checker.sv
sim/priority_queue_starvation_inherit_top_tb.sv
